// ===== hdl/ttlc_pkg.sv =====
// ----------------------------------------------------------------------------
// TTL cache package
// Shared types and constants for the lowest-TTL-eviction answer cache.
// ----------------------------------------------------------------------------
`default_nettype none

package ttlc_pkg;

   // Widest slot index for any supported cache depth (up to 64 entries).
   localparam int unsigned IDX_W  = 6;
   // Width of the slot number reported on the result port.
   localparam int unsigned SLOT_W = 3;

   typedef enum logic [1:0] {
      CMD_TICK   = 2'd0,
      CMD_LOOKUP = 2'd1,
      CMD_INSERT = 2'd2
   } cmd_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] name_id;
      logic [15:0] rec_type;
      logic [15:0] rec_class;
      logic [31:0] insert_ttl;
      logic [15:0] data_handle;
      logic [15:0] query_id;
   } req_type;

   typedef struct packed {
      logic              hit;
      logic [15:0]       hit_handle;
      logic [31:0]       ttl_left;
      logic [15:0]       reply_id;
      logic              evicted;
      logic [15:0]       evicted_handle;
      logic [SLOT_W-1:0] slot;
   } rsp_type;

   // One stored record.
   typedef struct packed {
      logic [31:0] name_id;
      logic [15:0] rec_type;
      logic [15:0] rec_class;
      logic [31:0] ttl;
      logic [15:0] handle;
   } entry_type;

   // Partial search result handed from one cell to the next.
   typedef struct packed {
      logic             hit;
      logic [IDX_W-1:0] hit_idx;
      logic [15:0]      hit_handle;
      logic [31:0]      hit_ttl;
      logic             low_found;
      logic [IDX_W-1:0] low_idx;
      logic [31:0]      low_ttl;
      logic [15:0]      low_handle;
   } carry_type;

   // Per-cell control from the sequencer.
   typedef struct packed {
      logic             live;
      logic             tick;
      logic             wr_en;
      logic [IDX_W-1:0] wr_slot;
   } cell_ctl_type;

endpackage

`default_nettype wire

// ===== hdl/ttl_cache_lowest_ttl_evict.sv =====
// ----------------------------------------------------------------------------
// TTL answer cache with lowest-TTL eviction
// Fully associative cache of ENTRIES answer records held in a chain of cells.
// ----------------------------------------------------------------------------
// A tick goes from idle straight to the finish state; a lookup, an insert or
// an unused command passes through the scan state first, because the search
// result ripples one cell per clock through the chain before the sequencer
// acts on it. busy is high from the accepting edge until the result is
// driven, and a new command may be started in the cycle the result strobe is
// shown. The result is valid for exactly one cycle and cannot be stalled.
`default_nettype none

module ttl_cache_lowest_ttl_evict #(
   parameter int unsigned ENTRIES = 8
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               start,
   output logic              busy,
   input  ttlc_pkg::req_type req_data,
   output logic              rsp_valid,
   output ttlc_pkg::rsp_type rsp_data
);

   localparam int unsigned IDX_W = ttlc_pkg::IDX_W;
   localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SCAN   = 3'b010,
      S_FINISH = 3'b100
   } state_type;

   state_type              state_ff, state_in;
   logic [IDX_W-1:0]       scan_ff, scan_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   ttlc_pkg::req_type      req_ff, req_in;
   ttlc_pkg::rsp_type      rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   ttlc_pkg::entry_type    req_entry;
   ttlc_pkg::carry_type    carry [ENTRIES];
   ttlc_pkg::carry_type    seed;
   ttlc_pkg::carry_type    final_carry;
   logic                   do_tick;
   logic                   do_write;
   logic [IDX_W-1:0]       wr_slot;
   logic                   accept;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   assign req_entry.name_id   = req_ff.name_id;
   assign req_entry.rec_type  = req_ff.rec_type;
   assign req_entry.rec_class = req_ff.rec_class;
   assign req_entry.ttl       = req_ff.insert_ttl;
   assign req_entry.handle    = req_ff.data_handle;

   assign seed        = '0;
   assign final_carry = carry[ENTRIES-1];

   genvar gi;
   generate
      for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
         ttlc_pkg::cell_ctl_type ctl;
         assign ctl.live    = (CNT_W'(gi) < count_ff);
         assign ctl.tick    = do_tick;
         assign ctl.wr_en   = do_write;
         assign ctl.wr_slot = wr_slot;
         if (gi == 0) begin : g_head
            ttlc_cell #(.INDEX(gi)) u_cell (
               .clock      (clock),
               .ctl        (ctl),
               .req_entry  (req_entry),
               .prev_carry (seed),
               .carry_out  (carry[gi])
            );
         end else begin : g_body
            ttlc_cell #(.INDEX(gi)) u_cell (
               .clock      (clock),
               .ctl        (ctl),
               .req_entry  (req_entry),
               .prev_carry (carry[gi-1]),
               .carry_out  (carry[gi])
            );
         end
      end
   endgenerate

   // Final decision once the chain has settled.
   always_comb begin
      logic append;
      append   = (!final_carry.low_found || final_carry.low_ttl != 32'd0) &&
                 (count_ff < CNT_W'(ENTRIES));
      do_tick  = 1'b0;
      do_write = 1'b0;
      wr_slot  = final_carry.low_idx;
      count_in = count_ff;
      rsp_in   = '0;
      if (state_ff == S_FINISH) begin
         unique case (req_ff.cmd)
            ttlc_pkg::CMD_TICK: begin
               do_tick = 1'b1;
            end
            ttlc_pkg::CMD_LOOKUP: begin
               if (final_carry.hit) begin
                  rsp_in.hit        = 1'b1;
                  rsp_in.hit_handle = final_carry.hit_handle;
                  rsp_in.ttl_left   = final_carry.hit_ttl;
                  rsp_in.reply_id   = req_ff.query_id;
                  rsp_in.slot       = final_carry.hit_idx[ttlc_pkg::SLOT_W-1:0];
               end
            end
            ttlc_pkg::CMD_INSERT: begin
               do_write = 1'b1;
               if (append) begin
                  wr_slot  = IDX_W'(count_ff);
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  rsp_in.evicted        = 1'b1;
                  rsp_in.evicted_handle = final_carry.low_handle;
               end
               rsp_in.slot = wr_slot[ttlc_pkg::SLOT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      scan_in      = scan_ff;
      req_in       = req_ff;
      rsp_valid_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in  = req_data;
               scan_in = '0;
               state_in = (req_data.cmd == ttlc_pkg::CMD_TICK) ? S_FINISH : S_SCAN;
            end
         end
         S_SCAN: begin
            scan_in = scan_ff + IDX_W'(1);
            if (scan_ff == IDX_W'(ENTRIES - 1)) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      req_ff  <= req_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_rsp_after_finish : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) == S_FINISH)
      else $error("result strobe without a finished command");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(ENTRIES))
      else $error("entry count above cache depth");

   a_hit_live : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.hit |-> rsp_data.ttl_left != 32'd0 && !rsp_data.evicted)
      else $error("hit on an expired entry or mixed with eviction");

   a_evict_full : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.evicted && $past(count_ff) != CNT_W'(ENTRIES)
      |-> $past(final_carry.low_ttl) == 32'd0)
      else $error("eviction with free space and no expired entry");
`endif

endmodule

`default_nettype wire

// ===== hdl/ttlc_cell.sv =====
// ----------------------------------------------------------------------------
// TTL cache cell
// Holds one cache entry and folds it into the search result passed down the
// chain: first live key match, and first entry with the lowest TTL.
// ----------------------------------------------------------------------------
`default_nettype none

module ttlc_cell #(
   parameter int unsigned INDEX = 0
) (
   input  wire                   clock,
   input  ttlc_pkg::cell_ctl_type ctl,
   input  ttlc_pkg::entry_type   req_entry,
   input  ttlc_pkg::carry_type   prev_carry,
   output ttlc_pkg::carry_type   carry_out
);

   localparam logic [ttlc_pkg::IDX_W-1:0] MY_IDX = ttlc_pkg::IDX_W'(INDEX);

   ttlc_pkg::entry_type entry_ff, entry_in;
   ttlc_pkg::carry_type carry_ff, carry_in;
   logic                match;

   assign match = ctl.live && (entry_ff.name_id == req_entry.name_id) &&
                  (entry_ff.rec_type == req_entry.rec_type) &&
                  (entry_ff.rec_class == req_entry.rec_class) &&
                  (entry_ff.ttl != 32'd0);

   always_comb begin
      carry_in = prev_carry;
      if (!prev_carry.hit && match) begin
         carry_in.hit        = 1'b1;
         carry_in.hit_idx    = MY_IDX;
         carry_in.hit_handle = entry_ff.handle;
         carry_in.hit_ttl    = entry_ff.ttl;
      end
      // Strict compare keeps the lowest slot on a tie.
      if (ctl.live && (!prev_carry.low_found || entry_ff.ttl < prev_carry.low_ttl)) begin
         carry_in.low_found  = 1'b1;
         carry_in.low_idx    = MY_IDX;
         carry_in.low_ttl    = entry_ff.ttl;
         carry_in.low_handle = entry_ff.handle;
      end
   end

   always_comb begin
      entry_in = entry_ff;
      if (ctl.wr_en && ctl.wr_slot == MY_IDX) begin
         entry_in = req_entry;
      end else if (ctl.tick && ctl.live && entry_ff.ttl != 32'd0) begin
         entry_in.ttl = entry_ff.ttl - 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      carry_ff <= carry_in;
   end

   assign carry_out = carry_ff;

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// Testbench for the TTL answer cache with lowest-TTL eviction
// Sends tick, lookup, insert and unused commands through the start/busy
// handshake. A software mirror of the cache predicts every answer, and each
// answer strobe is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

   localparam int unsigned CACHE_DEPTH  = 8;
   localparam int unsigned RANDOM_ITEMS = 650;
   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam logic [1:0]  CMD_UNUSED   = 2'd3;

   // Mirror of the cache contents that predicts one answer per command.
   class record_cache_mirror;
      ttlc_pkg::entry_type stored[CACHE_DEPTH];
      int unsigned         fill;
      ttlc_pkg::rsp_type   expected_answers[$];
      int unsigned         errors;
      int unsigned         n_tick, n_lookup, n_insert, n_unused;
      int unsigned         n_hits, n_evictions, n_checked;

      function new();
         fill   = 0;
         errors = 0;
      endfunction

      function int unsigned pending();
         return expected_answers.size();
      endfunction

      function void note_command(ttlc_pkg::req_type cmd_in);
         ttlc_pkg::rsp_type ans;
         logic              found;
         logic [31:0]       low_ttl;
         int unsigned       low_idx;
         int unsigned       target;
         ans = '0;
         case (ttlc_pkg::cmd_type'(cmd_in.cmd))
            ttlc_pkg::CMD_TICK: begin
               n_tick++;
               for (int unsigned i = 0; i < fill; i++)
                  if (stored[i].ttl != 0) stored[i].ttl = stored[i].ttl - 1;
            end
            ttlc_pkg::CMD_LOOKUP: begin
               n_lookup++;
               found = 1'b0;
               for (int unsigned i = 0; i < fill; i++) begin
                  if (!found && stored[i].name_id == cmd_in.name_id &&
                      stored[i].rec_type == cmd_in.rec_type &&
                      stored[i].rec_class == cmd_in.rec_class && stored[i].ttl != 0) begin
                     found          = 1'b1;
                     ans.hit        = 1'b1;
                     ans.hit_handle = stored[i].handle;
                     ans.ttl_left   = stored[i].ttl;
                     ans.reply_id   = cmd_in.query_id;
                     ans.slot       = i[ttlc_pkg::SLOT_W-1:0];
                  end
               end
               if (found) n_hits++;
            end
            ttlc_pkg::CMD_INSERT: begin
               n_insert++;
               found   = 1'b0;
               low_ttl = '0;
               low_idx = 0;
               for (int unsigned i = 0; i < fill; i++) begin
                  if (!found || stored[i].ttl < low_ttl) begin
                     low_ttl = stored[i].ttl;
                     low_idx = i;
                     found   = 1'b1;
                  end
               end
               // Append only while there is room and nothing has expired.
               if ((!found || low_ttl != 0) && fill < CACHE_DEPTH) begin
                  target = fill;
                  fill++;
               end else begin
                  target             = low_idx;
                  ans.evicted        = 1'b1;
                  ans.evicted_handle = stored[low_idx].handle;
                  n_evictions++;
               end
               stored[target].name_id   = cmd_in.name_id;
               stored[target].rec_type  = cmd_in.rec_type;
               stored[target].rec_class = cmd_in.rec_class;
               stored[target].ttl       = cmd_in.insert_ttl;
               stored[target].handle    = cmd_in.data_handle;
               ans.slot                 = target[ttlc_pkg::SLOT_W-1:0];
            end
            default: n_unused++;
         endcase
         expected_answers.push_back(ans);
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("answer field %s: expected 0x%0h, got 0x%0h", field, want, got);
            errors++;
         end
      endfunction

      function void check_answer(ttlc_pkg::rsp_type got);
         ttlc_pkg::rsp_type want;
         if (expected_answers.size() == 0) begin
            $error("answer strobe with no command outstanding");
            errors++;
            return;
         end
         want = expected_answers.pop_front();
         n_checked++;
         compare_field("hit", 32'(want.hit), 32'(got.hit));
         compare_field("hit_handle", 32'(want.hit_handle), 32'(got.hit_handle));
         compare_field("ttl_left", want.ttl_left, got.ttl_left);
         compare_field("reply_id", 32'(want.reply_id), 32'(got.reply_id));
         compare_field("evicted", 32'(want.evicted), 32'(got.evicted));
         compare_field("evicted_handle", 32'(want.evicted_handle), 32'(got.evicted_handle));
         compare_field("slot", 32'(want.slot), 32'(got.slot));
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset;
   logic              start;
   logic              busy;
   ttlc_pkg::req_type req;
   logic              rsp_valid;
   ttlc_pkg::rsp_type rsp;

   record_cache_mirror mirror = new();
   int unsigned        cycle_count = 0;

   logic [31:0] key_name[6];
   logic [15:0] key_type[6];
   logic [15:0] key_class[6];

   ttl_cache_lowest_ttl_evict #(
      .ENTRIES(CACHE_DEPTH)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Answers are checked before the command accepted at the same edge is noted;
   // the queue keeps them in order either way.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid === 1'b1) mirror.check_answer(rsp);
         if (start && !busy) mirror.note_command(req);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d answers outstanding",
                  cycle_count, mirror.pending());
         $display("ttl_cache_lowest_ttl_evict verification failed");
         $finish;
      end
   end

   function automatic ttlc_pkg::req_type make_item(logic [1:0] cmd, logic [31:0] name_id,
                                                   logic [15:0] rec_type,
                                                   logic [15:0] rec_class,
                                                   logic [31:0] ttl, logic [15:0] handle,
                                                   logic [15:0] qid);
      ttlc_pkg::req_type item;
      item.cmd         = cmd;
      item.name_id     = name_id;
      item.rec_type    = rec_type;
      item.rec_class   = rec_class;
      item.insert_ttl  = ttl;
      item.data_handle = handle;
      item.query_id    = qid;
      return item;
   endfunction

   function automatic ttlc_pkg::req_type random_item();
      ttlc_pkg::req_type item;
      int unsigned       pick;
      int unsigned       k;
      int unsigned       b;
      int unsigned       bit_pos;
      item = make_item(2'(ttlc_pkg::CMD_TICK), $urandom, 16'($urandom), 16'($urandom),
                       $urandom, 16'($urandom), 16'($urandom));
      pick = $urandom_range(0, 99);
      if (pick < 24)      item.cmd = ttlc_pkg::CMD_TICK;
      else if (pick < 60) item.cmd = ttlc_pkg::CMD_LOOKUP;
      else if (pick < 95) item.cmd = ttlc_pkg::CMD_INSERT;
      else                item.cmd = CMD_UNUSED;
      // Most keys come from a small set so that lookups find stored records.
      if ($urandom_range(0, 99) < 85) begin
         k              = $urandom_range(0, 5);
         item.name_id   = key_name[k];
         item.rec_type  = key_type[k];
         item.rec_class = key_class[k];
         if (item.cmd == ttlc_pkg::CMD_LOOKUP && $urandom_range(0, 9) == 0) begin
            b = $urandom_range(0, 2);
            if (b == 0) begin
               bit_pos               = $urandom_range(0, 31);
               item.name_id[bit_pos] = ~item.name_id[bit_pos];
            end else if (b == 1) begin
               bit_pos                = $urandom_range(0, 15);
               item.rec_type[bit_pos] = ~item.rec_type[bit_pos];
            end else begin
               bit_pos                 = $urandom_range(0, 15);
               item.rec_class[bit_pos] = ~item.rec_class[bit_pos];
            end
         end
      end
      pick = $urandom_range(0, 99);
      if (pick < 10)      item.insert_ttl = '0;
      else if (pick < 85) item.insert_ttl = $urandom_range(1, 12);
      else if (pick < 95) item.insert_ttl = $urandom;
      else                item.insert_ttl = '1;
      return item;
   endfunction

   // Holds start high until the block takes the transfer.
   task automatic issue(input ttlc_pkg::req_type item);
      req   <= item;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic idle_cycles(input int unsigned n);
      start <= 1'b0;
      req   <= make_item(2'($urandom), $urandom, 16'($urandom), 16'($urandom),
                         $urandom, 16'($urandom), 16'($urandom));
      repeat (n) @(posedge clock);
   endtask

   task automatic wait_all_answered();
      start <= 1'b0;
      @(posedge clock);
      while (mirror.pending() != 0) @(posedge clock);
   endtask

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req   <= '0;
      for (int i = 0; i < 6; i++) begin
         key_name[i]  = $urandom;
         key_type[i]  = 16'($urandom);
         key_class[i] = 16'($urandom);
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: empty cache, extremes, expiry, replacement and ties.
      issue(make_item(ttlc_pkg::CMD_LOOKUP, '1, '1, '1, '1, '1, '1));
      issue(make_item(ttlc_pkg::CMD_TICK, '1, '1, '1, '1, '1, '1));
      issue(make_item(CMD_UNUSED, '1, '1, '1, '1, '1, '1));
      issue(make_item(ttlc_pkg::CMD_INSERT, '1, '1, '1, '1, '1, '0));
      issue(make_item(ttlc_pkg::CMD_LOOKUP, '1, '1, '1, '0, '0, '1));
      issue(make_item(ttlc_pkg::CMD_INSERT, '0, '0, '0, '0, '0, '0));
      issue(make_item(ttlc_pkg::CMD_LOOKUP, '0, '0, '0, '0, '0, 16'h1234));
      // The zero-TTL record is replaced although free slots remain.
      issue(make_item(ttlc_pkg::CMD_INSERT, 32'h1, 16'h1, 16'h1, 32'd3, 16'h1234, '0));
      issue(make_item(ttlc_pkg::CMD_INSERT, 32'h2, 16'h1, 16'h1, 32'd1, 16'h2222, '0));
      issue(make_item(ttlc_pkg::CMD_TICK, '0, '0, '0, '0, '0, '0));
      issue(make_item(ttlc_pkg::CMD_LOOKUP, 32'h2, 16'h1, 16'h1, '0, '0, 16'h0042));
      issue(make_item(ttlc_pkg::CMD_LOOKUP, '1, '1, '1, '0, '0, '0));
      issue(make_item(ttlc_pkg::CMD_TICK, '0, '0, '0, '0, '0, '0));
      issue(make_item(ttlc_pkg::CMD_TICK, '0, '0, '0, '0, '0, '0));
      issue(make_item(ttlc_pkg::CMD_INSERT, 32'h3, 16'h2, 16'h3, 32'd7, 16'h3333, '0));
      issue(make_item(ttlc_pkg::CMD_INSERT, 32'h4, 16'h2, 16'h3, 32'd7, 16'h4444, '0));
      for (int i = 0; i < 5; i++)
         issue(make_item(ttlc_pkg::CMD_INSERT, 32'h10 + i, 16'h5, 16'h6,
                         32'h8000_0000 + i, 16'h5000 + 16'(i), '0));
      // Full cache, several records at the lowest TTL: the lowest slot goes.
      issue(make_item(ttlc_pkg::CMD_INSERT, 32'h1, 16'h1, 16'h1, 32'h7fff_ffff,
                      16'h6666, '0));
      issue(make_item(ttlc_pkg::CMD_INSERT, '1, '1, '1, 32'd9, 16'h7777, '0));
      issue(make_item(ttlc_pkg::CMD_LOOKUP, '1, '1, '1, '0, '0, 16'hbeef));
      wait_all_answered();

      for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 400 || n == 550) wait_all_answered();
         if ((n < 200 || n >= 350) && $urandom_range(0, 99) < 9)
            idle_cycles($urandom_range(1, 12));
         issue(random_item());
      end

      wait_all_answered();
      repeat (CACHE_DEPTH + 4) @(posedge clock);
      $display("sent %0d ticks, %0d lookups, %0d inserts and %0d unused commands",
               mirror.n_tick, mirror.n_lookup, mirror.n_insert, mirror.n_unused);
      $display("checked %0d answers: %0d lookup hits, %0d evictions, %0d outstanding",
               mirror.n_checked, mirror.n_hits, mirror.n_evictions, mirror.pending());
      if (mirror.errors == 0 && mirror.pending() == 0) begin
         $display("ttl_cache_lowest_ttl_evict verification clean");
      end else begin
         $display("ttl_cache_lowest_ttl_evict verification failed");
      end
      $finish;
   end
endmodule
